@@ hw/rtl/keyboard_scancode_queue_with_modifiers_assert.svh @@
// ----------------------------------------------------------------------------
// keyboard_scancode_queue_with_modifiers_assert.svh
// Assertion macros for the scancode queue.
// ----------------------------------------------------------------------------
`ifndef KEYBOARD_SCANCODE_QUEUE_WITH_MODIFIERS_ASSERT_SVH
`define KEYBOARD_SCANCODE_QUEUE_WITH_MODIFIERS_ASSERT_SVH

// same-cycle implication
`define KBQ_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("kbq: check failed");

// next-cycle implication
`define KBQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("kbq: check failed");

`endif

@@ hw/rtl/kbq_pkg.sv @@
// ----------------------------------------------------------------------------
// kbq_pkg
// Types, constants and keymap tables for the scancode queue.
// ----------------------------------------------------------------------------
`default_nettype none

package kbq_pkg;

  localparam int unsigned QUEUE_DEPTH = 2048;
  localparam int unsigned PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned TABLE_LEN   = 58;
  localparam int unsigned ENTRY_W     = 11;

  typedef enum logic [1:0] {
    CMD_FEED = 2'd0,
    CMD_POP  = 2'd1,
    CMD_TAKE = 2'd2
  } cmd_e;

  localparam logic [7:0] SC_ESC        = 8'h01;
  localparam logic [7:0] SC_LSHIFT     = 8'h2A;
  localparam logic [7:0] SC_RSHIFT     = 8'h36;
  localparam logic [7:0] SC_LSHIFT_REL = 8'hAA;
  localparam logic [7:0] SC_RSHIFT_REL = 8'hB6;
  localparam logic [7:0] SC_CAPS       = 8'h3A;
  localparam logic [7:0] SC_CTRL       = 8'h1D;
  localparam logic [7:0] SC_CTRL_REL   = 8'h9D;
  localparam logic [7:0] SC_ALT        = 8'h38;
  localparam logic [7:0] SC_ALT_REL    = 8'hB8;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] popped_code;
    logic [2:0] popped_mods;
    logic [6:0] key_char;
    logic       entry_valid;
    logic       escape_seen;
    logic       byte_dropped;
  } out_t;

  function automatic logic [6:0] plain_char(input logic [5:0] idx);
    logic [6:0] c;
    case (idx)
      6'd1:  c = 7'h1B;  6'd2:  c = 7'h31;  6'd3:  c = 7'h32;  6'd4:  c = 7'h33;
      6'd5:  c = 7'h34;  6'd6:  c = 7'h35;  6'd7:  c = 7'h36;  6'd8:  c = 7'h37;
      6'd9:  c = 7'h38;  6'd10: c = 7'h39;  6'd11: c = 7'h30;  6'd12: c = 7'h2D;
      6'd13: c = 7'h3D;  6'd14: c = 7'h08;  6'd15: c = 7'h09;  6'd16: c = 7'h71;
      6'd17: c = 7'h77;  6'd18: c = 7'h65;  6'd19: c = 7'h72;  6'd20: c = 7'h74;
      6'd21: c = 7'h79;  6'd22: c = 7'h75;  6'd23: c = 7'h69;  6'd24: c = 7'h6F;
      6'd25: c = 7'h70;  6'd26: c = 7'h5B;  6'd27: c = 7'h5D;  6'd28: c = 7'h0A;
      6'd30: c = 7'h61;  6'd31: c = 7'h73;  6'd32: c = 7'h64;  6'd33: c = 7'h66;
      6'd34: c = 7'h67;  6'd35: c = 7'h68;  6'd36: c = 7'h6A;  6'd37: c = 7'h6B;
      6'd38: c = 7'h6C;  6'd39: c = 7'h3B;  6'd40: c = 7'h27;  6'd41: c = 7'h60;
      6'd43: c = 7'h5C;  6'd44: c = 7'h7A;  6'd45: c = 7'h78;  6'd46: c = 7'h63;
      6'd47: c = 7'h76;  6'd48: c = 7'h62;  6'd49: c = 7'h6E;  6'd50: c = 7'h6D;
      6'd51: c = 7'h2C;  6'd52: c = 7'h2E;  6'd53: c = 7'h2F;  6'd55: c = 7'h2A;
      6'd57: c = 7'h20;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

  function automatic logic [6:0] shifted_char(input logic [5:0] idx);
    logic [6:0] c;
    case (idx)
      6'd1:  c = 7'h1B;  6'd2:  c = 7'h21;  6'd3:  c = 7'h40;  6'd4:  c = 7'h23;
      6'd5:  c = 7'h24;  6'd6:  c = 7'h25;  6'd7:  c = 7'h5E;  6'd8:  c = 7'h26;
      6'd9:  c = 7'h2A;  6'd10: c = 7'h28;  6'd11: c = 7'h29;  6'd12: c = 7'h5F;
      6'd13: c = 7'h2B;  6'd14: c = 7'h08;  6'd15: c = 7'h09;  6'd16: c = 7'h51;
      6'd17: c = 7'h57;  6'd18: c = 7'h45;  6'd19: c = 7'h52;  6'd20: c = 7'h54;
      6'd21: c = 7'h59;  6'd22: c = 7'h55;  6'd23: c = 7'h49;  6'd24: c = 7'h4F;
      6'd25: c = 7'h50;  6'd26: c = 7'h7B;  6'd27: c = 7'h7D;  6'd28: c = 7'h0A;
      6'd30: c = 7'h41;  6'd31: c = 7'h53;  6'd32: c = 7'h44;  6'd33: c = 7'h46;
      6'd34: c = 7'h47;  6'd35: c = 7'h48;  6'd36: c = 7'h4A;  6'd37: c = 7'h4B;
      6'd38: c = 7'h4C;  6'd39: c = 7'h3A;  6'd40: c = 7'h22;  6'd41: c = 7'h7E;
      6'd43: c = 7'h7C;  6'd44: c = 7'h5A;  6'd45: c = 7'h58;  6'd46: c = 7'h43;
      6'd47: c = 7'h56;  6'd48: c = 7'h42;  6'd49: c = 7'h4E;  6'd50: c = 7'h4D;
      6'd51: c = 7'h3C;  6'd52: c = 7'h3E;  6'd53: c = 7'h3F;  6'd55: c = 7'h2A;
      6'd57: c = 7'h20;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/keyboard_scancode_queue_with_modifiers.sv @@
// ----------------------------------------------------------------------------
// keyboard_scancode_queue_with_modifiers
// Set-1 scancode queue with shift/ctrl/alt snapshot, caps lock and escape latch.
// ----------------------------------------------------------------------------
// The result beat is strobed by done_o in the cycle after start.
// Throughput: one command per clock; busy stays low, a pop reads the queue RAM
//   at accept and resolves the character from the registered read data.
// Reset: pointers, modifier flags, escape latch and strobe clear at once;
//   the queue RAM is not cleared. The receiver cannot stall results.
`default_nettype none

`include "keyboard_scancode_queue_with_modifiers_assert.svh"

module keyboard_scancode_queue_with_modifiers (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire kbq_pkg::in_t  in_i,
  output logic               done_o,
  output kbq_pkg::out_t      result_o
);

  localparam int unsigned PW = kbq_pkg::PTR_W;
  localparam logic [PW-1:0] LAST = PW'(kbq_pkg::QUEUE_DEPTH - 1);

  logic [PW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [PW-1:0] wr_next, rd_next;
  logic          shift_q, shift_d, ctrl_q, ctrl_d, alt_q, alt_d;
  logic          caps_q, caps_d, esc_q, esc_d;
  logic          done_q, hit_q, hit_d, seen_q, seen_d, drop_q, drop_d;
  logic          accept, is_feed, is_pop, is_take, full, empty;
  logic          push;
  logic [kbq_pkg::ENTRY_W-1:0] wdata, rdata;
  logic [6:0]    ch;

  assign busy    = 1'b0;
  assign accept  = start & ~busy;
  assign is_feed = accept & (in_i.command == kbq_pkg::CMD_FEED);
  assign is_pop  = accept & (in_i.command == kbq_pkg::CMD_POP);
  assign is_take = accept & (in_i.command == kbq_pkg::CMD_TAKE);

  assign wr_next = (wr_ptr_q == LAST) ? '0 : wr_ptr_q + PW'(1);
  assign rd_next = (rd_ptr_q == LAST) ? '0 : rd_ptr_q + PW'(1);
  assign full    = (wr_next == rd_ptr_q);
  assign empty   = (wr_ptr_q == rd_ptr_q);
  assign push    = is_feed & ~full;

  always_comb begin
    shift_d = shift_q;
    ctrl_d  = ctrl_q;
    alt_d   = alt_q;
    caps_d  = caps_q;
    esc_d   = esc_q;
    if (is_feed) begin
      case (in_i.data_byte)
        kbq_pkg::SC_ESC:        esc_d   = 1'b1;
        kbq_pkg::SC_LSHIFT:     shift_d = 1'b1;
        kbq_pkg::SC_RSHIFT:     shift_d = 1'b1;
        kbq_pkg::SC_LSHIFT_REL: shift_d = 1'b0;
        kbq_pkg::SC_RSHIFT_REL: shift_d = 1'b0;
        kbq_pkg::SC_CAPS:       caps_d  = ~caps_q;
        kbq_pkg::SC_CTRL:       ctrl_d  = 1'b1;
        kbq_pkg::SC_CTRL_REL:   ctrl_d  = 1'b0;
        kbq_pkg::SC_ALT:        alt_d   = 1'b1;
        kbq_pkg::SC_ALT_REL:    alt_d   = 1'b0;
        default: ;
      endcase
    end
    if (is_take) begin
      esc_d = 1'b0;
    end
  end

  always_comb begin
    wr_ptr_d = push ? wr_next : wr_ptr_q;
    rd_ptr_d = (is_pop & ~empty) ? rd_next : rd_ptr_q;
    hit_d    = is_pop & ~empty;
    seen_d   = is_take & esc_q;
    drop_d   = is_feed & full;
  end

  assign wdata = {alt_d, ctrl_d, shift_d, in_i.data_byte};

  kbq_ram #(
    .WIDTH (kbq_pkg::ENTRY_W),
    .DEPTH (kbq_pkg::QUEUE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (push),
    .waddr_i (wr_ptr_q),
    .wdata_i (wdata),
    .re_i    (is_pop),
    .raddr_i (rd_ptr_q),
    .rdata_o (rdata)
  );

  kbq_keymap u_keymap (
    .code_i  (rdata[7:0]),
    .shift_i (rdata[8]),
    .caps_i  (caps_q),
    .char_o  (ch)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      shift_q  <= 1'b0;
      ctrl_q   <= 1'b0;
      alt_q    <= 1'b0;
      caps_q   <= 1'b0;
      esc_q    <= 1'b0;
      done_q   <= 1'b0;
      hit_q    <= 1'b0;
      seen_q   <= 1'b0;
      drop_q   <= 1'b0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      shift_q  <= shift_d;
      ctrl_q   <= ctrl_d;
      alt_q    <= alt_d;
      caps_q   <= caps_d;
      esc_q    <= esc_d;
      done_q   <= accept;
      hit_q    <= hit_d;
      seen_q   <= seen_d;
      drop_q   <= drop_d;
    end
  end

  always_comb begin
    done_o                = done_q;
    result_o.popped_code  = hit_q ? rdata[7:0]  : 8'h00;
    result_o.popped_mods  = hit_q ? rdata[10:8] : 3'b000;
    result_o.key_char     = hit_q ? ch          : 7'h00;
    result_o.entry_valid  = hit_q;
    result_o.escape_seen  = seen_q;
    result_o.byte_dropped = drop_q;
  end

  `KBQ_ASSERT_NEXT(a_drop_holds_wptr, is_feed && full, wr_ptr_q == $past(wr_ptr_q) && drop_q)
  `KBQ_ASSERT_NEXT(a_empty_pop_miss, is_pop && empty, !hit_q && rd_ptr_q == $past(rd_ptr_q))
  `KBQ_ASSERT_NOW(a_flags_exclusive, done_q, $countones({hit_q, seen_q, drop_q}) <= 1)
  `KBQ_ASSERT_NOW(a_char_needs_hit, result_o.key_char != 7'h00, hit_q && done_q)

endmodule

`default_nettype wire

@@ hw/rtl/kbq_ram.sv @@
// ----------------------------------------------------------------------------
// kbq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module kbq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                         wdata_i,
  input  wire logic                                     re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/kbq_keymap.sv @@
// ----------------------------------------------------------------------------
// kbq_keymap
// Resolves a set-1 scancode to ASCII from the plain and shifted tables.
// ----------------------------------------------------------------------------
`default_nettype none

module kbq_keymap (
  input  wire logic [7:0] code_i,
  input  wire logic       shift_i,
  input  wire logic       caps_i,
  output logic      [6:0] char_o
);

  logic [6:0] lo;
  logic [6:0] hi;
  logic       letter;
  logic       upper;

  always_comb begin
    lo     = kbq_pkg::plain_char(code_i[5:0]);
    hi     = kbq_pkg::shifted_char(code_i[5:0]);
    letter = lo inside {[7'h61:7'h7A]};
    upper  = shift_i ^ (letter & caps_i);
    if (code_i >= 8'(kbq_pkg::TABLE_LEN)) begin
      char_o = 7'h00;
    end else begin
      char_o = upper ? hi : lo;
    end
  end

endmodule

`default_nettype wire
